>>> rtl/pfa_pkg.sv
// pfa_pkg: shared types, constants and helper functions of the page frame allocator
// depends on nothing; used by every module under rtl except pfa_ram

package pfa_pkg;

    // page geometry and register widths
    localparam int PAGE_SHIFT  = 12;
    localparam int ADDR_W      = 32;
    localparam int IDX_W       = 13;
    localparam int PAGE_IDX_W  = ADDR_W - PAGE_SHIFT;
    localparam int FREE_W      = 13;
    localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};

    // in-use bitmap geometry: one row holds the flags of 64 pages
    localparam int ROW_W       = 64;
    localparam int BIT_W       = 6;
    localparam int PROW_W      = IDX_W - BIT_W;

    // default page store depth
    localparam int PAGES_DEFAULT = 4096;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT   = 1'b1;
    localparam logic [IDX_W-1:0] FIRST_RESET = 13'd0;
    localparam logic [IDX_W-1:0] COUNT_RESET = 13'd4096;

    // request modes
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_OOM           = 3'd1,
        ST_MISALIGNED    = 3'd2,
        ST_RANGE         = 3'd3,
        ST_NOT_ALLOCATED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_REJECT  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        status_t           status;
        logic [IDX_W-1:0]  idx;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] lim;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_SCAN  = 2'd2,
        BK_REL   = 2'd3
    } bk_state_t;

    // page count clipped to the store depth
    function automatic logic [IDX_W-1:0] eff_limit(input logic [IDX_W-1:0] count,
                                                   input int pages);
        logic [IDX_W-1:0] res;
        if (int'(count) < pages) begin
            res = count;
        end else begin
            res = IDX_W'(pages);
        end
        return res;
    endfunction

    // free counter value after a register write
    function automatic logic [FREE_W-1:0] free_reload(input logic [IDX_W-1:0] first,
                                                      input logic [IDX_W-1:0] lim);
        logic [FREE_W-1:0] res;
        if (lim > first) begin
            res = FREE_W'(lim - first);
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

>>> rtl/pfa_ram.sv
// pfa_ram: generic single-write, single-read memory with registered read data
// depends on nothing

module pfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pfa_front.sv
// pfa_front: classifies incoming request words into allocator commands
// depends on pfa_pkg

module pfa_front (
    input  logic                         s_mode,
    input  logic [pfa_pkg::ADDR_W-1:0]   s_page_address,
    input  pfa_pkg::cfg_t                cfg,
    output pfa_pkg::cmd_t                cmd
);

    logic [pfa_pkg::PAGE_IDX_W-1:0] page_idx;
    logic [pfa_pkg::PAGE_IDX_W-1:0] first_ext;
    logic [pfa_pkg::PAGE_IDX_W-1:0] lim_ext;

    assign page_idx  = s_page_address[pfa_pkg::ADDR_W-1:pfa_pkg::PAGE_SHIFT];
    assign first_ext = pfa_pkg::PAGE_IDX_W'(cfg.first);
    assign lim_ext   = pfa_pkg::PAGE_IDX_W'(cfg.lim);

    // release checks go alignment, range, then in-use in the back end
    always_comb begin
        cmd.kind   = pfa_pkg::CMD_REJECT;
        cmd.status = pfa_pkg::ST_OK;
        cmd.idx    = page_idx[pfa_pkg::IDX_W-1:0];
        priority if (s_mode == pfa_pkg::MODE_ALLOC) begin
            if (cfg.first >= cfg.lim) begin
                cmd.status = pfa_pkg::ST_OOM;
            end else begin
                cmd.kind = pfa_pkg::CMD_ALLOC;
            end
        end else if (s_page_address[pfa_pkg::PAGE_SHIFT-1:0] != '0) begin
            cmd.status = pfa_pkg::ST_MISALIGNED;
        end else if (page_idx < first_ext || page_idx >= lim_ext) begin
            cmd.status = pfa_pkg::ST_RANGE;
        end else begin
            cmd.kind = pfa_pkg::CMD_RELEASE;
        end
    end

endmodule

>>> rtl/pfa_cmd_queue.sv
// pfa_cmd_queue: short fifo of classified commands between front and back
// depends on pfa_pkg

module pfa_cmd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pfa_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output pfa_pkg::cmd_t head_cmd
);

    localparam int DEPTH = pfa_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pfa_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

endmodule

>>> rtl/pfa_back.sv
// pfa_back: executes commands against the in-use bitmap and holds the result register
// depends on pfa_pkg and pfa_ram

module pfa_back #(
    parameter int PAGES = pfa_pkg::PAGES_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pfa_pkg::cfg_t                 cfg,
    input  logic                          reload,
    input  logic [pfa_pkg::FREE_W-1:0]    reload_value,
    input  logic                          q_valid,
    input  pfa_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pfa_pkg::ADDR_W-1:0]    m_granted_address,
    output logic [2:0]                    m_status,
    output logic [pfa_pkg::FREE_W-1:0]    m_free_count
);

    localparam int ROWS   = (PAGES + pfa_pkg::ROW_W - 1) / pfa_pkg::ROW_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RW     = pfa_pkg::ROW_W;
    localparam int PRW    = pfa_pkg::PROW_W;
    localparam int BW     = pfa_pkg::BIT_W;
    localparam logic [pfa_pkg::FREE_W-1:0] FREE_RESET =
        pfa_pkg::free_reload(pfa_pkg::FIRST_RESET,
                             pfa_pkg::eff_limit(pfa_pkg::COUNT_RESET, PAGES));

    pfa_pkg::bk_state_t state_reg, state_next;
    logic [ROW_AW-1:0]  clr_row_reg, clr_row_next;
    logic [PRW-1:0]     rd_row_reg, rd_row_next;
    logic [BW-1:0]      bit_reg, bit_next;
    logic [pfa_pkg::FREE_W-1:0] free_reg, free_next;

    logic                        m_valid_reg, m_valid_next;
    logic [pfa_pkg::ADDR_W-1:0]  m_granted_reg, m_granted_next;
    pfa_pkg::status_t            m_status_reg, m_status_next;
    logic [pfa_pkg::FREE_W-1:0]  m_free_reg, m_free_next;

    logic              ram_we, ram_re;
    logic [ROW_AW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0]     ram_wdata, ram_rdata;
    logic [PRW-1:0]    rd_row_sel;
    logic [ROW_AW+PRW-1:0] raddr_ext, waddr_ext;

    logic              out_free;
    logic              load;
    logic [pfa_pkg::ADDR_W-1:0] load_granted;
    pfa_pkg::status_t  load_status;

    logic [PRW-1:0]    first_row, last_row;
    logic [pfa_pkg::IDX_W-1:0] lim_m1;
    logic [RW-1:0]     lo_mask, hi_mask, free_bits;
    logic [BW-1:0]     ffs_pos;
    logic              ffs_hit;
    logic [pfa_pkg::FREE_W-1:0] free_dec, free_inc;

    // in-use bitmap, one flag per page, 64 pages per row
    pfa_ram #(
        .WIDTH (RW),
        .DEPTH (ROWS)
    ) u_used_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // row bounds of the usable page window
    assign lim_m1    = cfg.lim - 1'b1;
    assign first_row = cfg.first[pfa_pkg::IDX_W-1:BW];
    assign last_row  = lim_m1[pfa_pkg::IDX_W-1:BW];

    // free pages of the row under scan, limited to the usable window
    always_comb begin
        lo_mask = {RW{1'b1}};
        hi_mask = {RW{1'b1}};
        if (rd_row_reg == first_row) begin
            lo_mask = {RW{1'b1}} << cfg.first[BW-1:0];
        end
        if (rd_row_reg == last_row) begin
            hi_mask = {RW{1'b1}} >> (BW'(RW - 1) - lim_m1[BW-1:0]);
        end
        free_bits = ~ram_rdata & lo_mask & hi_mask;
    end

    // lowest free page in the row
    always_comb begin
        ffs_pos = '0;
        for (int i = RW - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                ffs_pos = BW'(i);
            end
        end
        ffs_hit = |free_bits;
    end

    // saturating free counter steps
    assign free_dec = (free_reg != '0) ? free_reg - 1'b1 : free_reg;
    assign free_inc = (free_reg != pfa_pkg::FREE_MAX) ? free_reg + 1'b1 : free_reg;

    assign out_free = !m_valid_reg || m_ready;

    // row index to memory address
    assign raddr_ext = {{ROW_AW{1'b0}}, rd_row_sel};
    assign waddr_ext = {{ROW_AW{1'b0}}, rd_row_reg};

    // sequencer: clearing pass, command dispatch, row scan, release update
    always_comb begin
        state_next   = state_reg;
        clr_row_next = clr_row_reg;
        rd_row_next  = rd_row_reg;
        bit_next     = bit_reg;
        free_next    = free_reg;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = waddr_ext[ROW_AW-1:0];
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        rd_row_sel   = rd_row_reg;
        load         = 1'b0;
        load_granted = '0;
        load_status  = pfa_pkg::ST_OK;

        unique case (state_reg)
            pfa_pkg::BK_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_row_reg;
                ram_wdata = '0;
                if (clr_row_reg == ROW_AW'(ROWS - 1)) begin
                    state_next = pfa_pkg::BK_IDLE;
                end else begin
                    clr_row_next = clr_row_reg + 1'b1;
                end
            end
            pfa_pkg::BK_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    unique case (q_cmd.kind)
                        pfa_pkg::CMD_ALLOC: begin
                            ram_re      = 1'b1;
                            rd_row_sel  = first_row;
                            rd_row_next = first_row;
                            state_next  = pfa_pkg::BK_SCAN;
                        end
                        pfa_pkg::CMD_RELEASE: begin
                            ram_re      = 1'b1;
                            rd_row_sel  = q_cmd.idx[pfa_pkg::IDX_W-1:BW];
                            rd_row_next = q_cmd.idx[pfa_pkg::IDX_W-1:BW];
                            bit_next    = q_cmd.idx[BW-1:0];
                            state_next  = pfa_pkg::BK_REL;
                        end
                        default: begin
                            load        = 1'b1;
                            load_status = q_cmd.status;
                        end
                    endcase
                end
            end
            pfa_pkg::BK_SCAN: begin
                priority if (ffs_hit) begin
                    ram_we       = 1'b1;
                    ram_wdata    = ram_rdata | (RW'(1) << ffs_pos);
                    free_next    = free_dec;
                    load         = 1'b1;
                    load_granted = pfa_pkg::ADDR_W'({rd_row_reg, ffs_pos,
                                                     {pfa_pkg::PAGE_SHIFT{1'b0}}});
                    state_next   = pfa_pkg::BK_IDLE;
                end else if (rd_row_reg == last_row) begin
                    load        = 1'b1;
                    load_status = pfa_pkg::ST_OOM;
                    state_next  = pfa_pkg::BK_IDLE;
                end else begin
                    ram_re      = 1'b1;
                    rd_row_sel  = rd_row_reg + 1'b1;
                    rd_row_next = rd_row_reg + 1'b1;
                end
            end
            pfa_pkg::BK_REL: begin
                load       = 1'b1;
                state_next = pfa_pkg::BK_IDLE;
                if (ram_rdata[bit_reg]) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~(RW'(1) << bit_reg);
                    free_next = free_inc;
                end else begin
                    load_status = pfa_pkg::ST_NOT_ALLOCATED;
                end
            end
            default: begin
                state_next = pfa_pkg::BK_IDLE;
            end
        endcase

        // register write reloads the free counter
        if (reload) begin
            free_next = reload_value;
        end
    end

    assign ram_raddr = raddr_ext[ROW_AW-1:0];

    // result word register
    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_granted_next = m_granted_reg;
        m_status_next  = m_status_reg;
        m_free_next    = m_free_reg;
        if (load) begin
            m_valid_next   = 1'b1;
            m_granted_next = load_granted;
            m_status_next  = load_status;
            m_free_next    = free_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pfa_pkg::BK_CLEAR;
            clr_row_reg <= '0;
            free_reg    <= FREE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_row_reg <= clr_row_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_row_reg    <= rd_row_next;
        bit_reg       <= bit_next;
        m_granted_reg <= m_granted_next;
        m_status_reg  <= m_status_next;
        m_free_reg    <= m_free_next;
    end

    assign clearing          = (state_reg == pfa_pkg::BK_CLEAR);
    assign m_valid           = m_valid_reg;
    assign m_granted_address = m_granted_reg;
    assign m_status          = m_status_reg;
    assign m_free_count      = m_free_reg;

endmodule

>>> rtl/page_frame_refcount_allocator.sv
// page_frame_refcount_allocator: top level, configuration registers and block wiring
// depends on pfa_pkg, pfa_front, pfa_cmd_queue, pfa_back (and pfa_ram through pfa_back)

// First-fit page frame allocator for up to PAGES pages of 4 KiB. Each page carries an
// in-use flag (its reference count, which never exceeds one since allocation only claims
// free pages), kept in a memory of 64-page rows. After reset a clearing pass writes every
// row, one row a cycle; no word is accepted until it ends. An allocate is dispatched with
// a read of the row of first_usable_page, then scans rows up to the row holding the first
// free page or the last row of the window; the single read port of the bitmap, one row per
// cycle, paces the scan. A release reads the row, then checks the flag and, if it is set,
// writes the row back with the flag cleared; misaligned, out-of-range and empty-window
// requests are answered at dispatch with no bitmap access. A two-entry command queue lets
// request words be accepted while the back end works or a result word waits. Writing
// either configuration register reloads the free counter; write only while idle.

module page_frame_refcount_allocator #(
    parameter int PAGES = pfa_pkg::PAGES_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration port
    input  logic                             cfg_wr_en,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // request words
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_mode,
    input  logic [pfa_pkg::ADDR_W-1:0]       s_page_address,
    // result words
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [pfa_pkg::ADDR_W-1:0]       m_granted_address,
    output logic [2:0]                       m_status,
    output logic [pfa_pkg::FREE_W-1:0]       m_free_count
);

    logic [pfa_pkg::IDX_W-1:0]  first_reg, first_next;
    logic [pfa_pkg::IDX_W-1:0]  count_reg, count_next;
    logic [pfa_pkg::FREE_W-1:0] reload_value;
    pfa_pkg::cfg_t              cfg;

    pfa_pkg::cmd_t front_cmd, head_cmd;
    logic          q_full, q_valid, q_pop, q_push;
    logic          clearing;

    // configuration register writes
    always_comb begin
        first_next = first_reg;
        count_next = count_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                pfa_pkg::CFG_FIRST_USABLE: first_next = cfg_wr_data;
                pfa_pkg::CFG_PAGE_COUNT:   count_next = cfg_wr_data;
                default: begin
                    first_next = first_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= pfa_pkg::FIRST_RESET;
            count_reg <= pfa_pkg::COUNT_RESET;
        end else begin
            first_reg <= first_next;
            count_reg <= count_next;
        end
    end

    // effective window and free counter reload value
    assign cfg.first    = first_reg;
    assign cfg.lim      = pfa_pkg::eff_limit(count_reg, PAGES);
    assign reload_value = pfa_pkg::free_reload(first_next,
                                               pfa_pkg::eff_limit(count_next, PAGES));

    // front: classify request words
    pfa_front u_front (
        .s_mode         (s_mode),
        .s_page_address (s_page_address),
        .cfg            (cfg),
        .cmd            (front_cmd)
    );

    assign s_ready = !q_full && !clearing;
    assign q_push  = s_valid && s_ready;

    pfa_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (front_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    // back: bitmap access and result register
    pfa_back #(
        .PAGES (PAGES)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .reload            (cfg_wr_en),
        .reload_value      (reload_value),
        .q_valid           (q_valid),
        .q_cmd             (head_cmd),
        .q_pop             (q_pop),
        .clearing          (clearing),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted_address (m_granted_address),
        .m_status          (m_status),
        .m_free_count      (m_free_count)
    );

    // no request word is taken during the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn) clearing |-> !s_ready)
        else $error("request accepted during clearing pass");

    // the back end only pops a queued command
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> q_valid)
        else $error("pop from empty command queue");

    // a nonzero grant only comes with an ok status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_granted_address != '0) |-> (m_status == pfa_pkg::ST_OK))
        else $error("granted address with failing status");

endmodule

>>> verif/pfa_refcount_checker.sv
// pfa_refcount_checker: watches the request and result channels of the page frame allocator,
// keeps its own copy of the reference counts and free counter, and checks every result word
// depends on pfa_pkg for widths, modes, register indexes and status codes

module pfa_refcount_checker
    import pfa_pkg::*;
#(
    parameter int PAGES = PAGES_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_mode,
    input  logic [ADDR_W-1:0]     s_page_address,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [ADDR_W-1:0]     m_granted_address,
    input  logic [2:0]            m_status,
    input  logic [FREE_W-1:0]     m_free_count,
    output int                    failures,
    output int                    pending
);

    typedef struct packed {
        logic [ADDR_W-1:0] granted;
        status_t           status;
        logic [FREE_W-1:0] free;
    } page_answer_t;

    // shadow allocator state
    logic [7:0]        refcounts [PAGES];
    int unsigned       first_page;
    int unsigned       page_total;
    logic [FREE_W-1:0] free_left;

    page_answer_t answers_due [$];
    int           fail_count = 0;
    int           due_count  = 0;

    assign failures = fail_count;
    assign pending  = due_count;

    // page count clipped to the store depth
    function automatic int unsigned managed_limit();
        return (page_total < PAGES) ? page_total : PAGES;
    endfunction

    // free counter after a register write
    function automatic void reload_free_count();
        int unsigned lim;
        lim = managed_limit();
        free_left = (lim > first_page) ? FREE_W'(lim - first_page) : '0;
    endfunction

    // apply one request word to the shadow state and return the answer it must produce
    function automatic page_answer_t serve_request(input logic mode,
                                                   input logic [ADDR_W-1:0] addr);
        page_answer_t ans;
        int unsigned  lim;
        int unsigned  pg;
        int unsigned  idx;
        bit           found;
        lim         = managed_limit();
        ans.granted = '0;
        ans.status  = ST_OK;
        found       = 1'b0;
        if (mode == MODE_ALLOC) begin
            // first fit from the lowest usable page
            pg = first_page;
            while (!found && pg < lim) begin
                if (refcounts[pg] == 8'd0) begin
                    refcounts[pg] = 8'd1;
                    if (free_left != '0) begin
                        free_left = free_left - 1'b1;
                    end
                    ans.granted = ADDR_W'(pg) << PAGE_SHIFT;
                    found       = 1'b1;
                end else begin
                    pg++;
                end
            end
            if (!found) begin
                ans.status = ST_OOM;
            end
        end else begin
            // alignment first, then range, then whether the page is in use
            idx = addr >> PAGE_SHIFT;
            if (addr[PAGE_SHIFT-1:0] != '0) begin
                ans.status = ST_MISALIGNED;
            end else if (idx < first_page || idx >= lim) begin
                ans.status = ST_RANGE;
            end else if (refcounts[idx] == 8'd0) begin
                ans.status = ST_NOT_ALLOCATED;
            end else begin
                refcounts[idx] = refcounts[idx] - 8'd1;
                if (refcounts[idx] == 8'd0 && free_left != FREE_MAX) begin
                    free_left = free_left + 1'b1;
                end
            end
        end
        ans.free = free_left;
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] want,
                                   input logic [ADDR_W-1:0] got);
        if (fail_count < 40) begin
            $display("mismatch at %0t: %s, wanted 0x%0h, saw 0x%0h", $time, what, want, got);
        end
        fail_count++;
    endtask

    // sample both channels and the register port at each rising edge
    always @(posedge aclk) begin
        page_answer_t due;
        if (!aresetn) begin
            foreach (refcounts[p]) begin
                refcounts[p] = 8'd0;
            end
            first_page = 32'(FIRST_RESET);
            page_total = 32'(COUNT_RESET);
            reload_free_count();
            answers_due.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_FIRST_USABLE) begin
                    first_page = 32'(cfg_wr_data);
                end else if (cfg_index == CFG_PAGE_COUNT) begin
                    page_total = 32'(cfg_wr_data);
                end
                reload_free_count();
            end
            if (s_valid && s_ready) begin
                answers_due.push_back(serve_request(s_mode, s_page_address));
            end
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("result word with nothing outstanding", '0,
                                    m_granted_address);
                end else begin
                    due = answers_due.pop_front();
                    if (m_granted_address !== due.granted) begin
                        report_mismatch("granted_address", due.granted, m_granted_address);
                    end
                    if (m_status !== due.status) begin
                        report_mismatch("status", ADDR_W'(due.status), ADDR_W'(m_status));
                    end
                    if (m_free_count !== due.free) begin
                        report_mismatch("free_count", ADDR_W'(due.free), ADDR_W'(m_free_count));
                    end
                end
            end
        end
        due_count = answers_due.size();
    end

endmodule

>>> verif/tb_page_frame_refcount_allocator.sv
// tb_page_frame_refcount_allocator: drives request words, register writes and result stalls
// into the page frame allocator; depends on pfa_pkg, the rtl and pfa_refcount_checker

module tb_page_frame_refcount_allocator;
    import pfa_pkg::*;

    localparam int PAGES         = PAGES_DEFAULT;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 50;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = CFG_FIRST_USABLE;
    logic [CFG_DATA_W-1:0] cfg_wr_data    = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic                  s_mode         = MODE_ALLOC;
    logic [ADDR_W-1:0]     s_page_address = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [ADDR_W-1:0]     m_granted_address;
    logic [2:0]            m_status;
    logic [FREE_W-1:0]     m_free_count;

    int failures;
    int pending;
    int cycles = 0;

    // current window, used to aim release addresses
    bit          gaps_on   = 1'b1;
    int unsigned win_first = 0;
    int unsigned win_limit = PAGES;

    page_frame_refcount_allocator #(.PAGES(PAGES)) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_page_address    (s_page_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted_address (m_granted_address),
        .m_status          (m_status),
        .m_free_count      (m_free_count)
    );

    pfa_refcount_checker #(.PAGES(PAGES)) u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_page_address    (s_page_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted_address (m_granted_address),
        .m_status          (m_status),
        .m_free_count      (m_free_count),
        .failures          (failures),
        .pending           (pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side back-pressure: short stalls, some long ones, some free-running stretches
    initial begin
        int r;
        @(posedge aclk);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge aclk);
            end else if (r < 90) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(15, 60)) @(posedge aclk);
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // idle cycles before a request word: mostly none or a few, now and then a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // present one request word and hold it until accepted
    task automatic send_word(input logic mode, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_page_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // register write once every outstanding result has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_window(input int unsigned first, input int unsigned count);
        if ($urandom_range(0, 1) != 0) begin
            write_reg(CFG_FIRST_USABLE, CFG_DATA_W'(first));
            write_reg(CFG_PAGE_COUNT, CFG_DATA_W'(count));
        end else begin
            write_reg(CFG_PAGE_COUNT, CFG_DATA_W'(count));
            write_reg(CFG_FIRST_USABLE, CFG_DATA_W'(first));
        end
        win_first = first;
        win_limit = (count < PAGES) ? count : PAGES;
    endtask

    // release address: mostly pages likely in use, some at the window edges, some malformed
    function automatic logic [ADDR_W-1:0] pick_release(input int unsigned allocs);
        int unsigned r;
        int unsigned lo;
        int unsigned idx;
        r  = $urandom_range(0, 99);
        lo = (win_first >= 2) ? win_first - 2 : 0;
        if (r < 45) begin
            idx = $urandom_range(win_first + allocs + 1, win_first);
        end else if (r < 72) begin
            idx = $urandom_range(win_limit + 1, lo);
        end else if (r < 85) begin
            return {PAGE_IDX_W'($urandom_range(0, 32'hfffff)),
                    PAGE_SHIFT'($urandom_range(1, 4095))};
        end else begin
            return $urandom();
        end
        return ADDR_W'(idx) << PAGE_SHIFT;
    endfunction

    task automatic run_random_phase();
        int unsigned r;
        int unsigned first;
        int unsigned count;
        int unsigned allocs;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            // small window: runs out of pages quickly
            first = $urandom_range(0, 4090);
            count = first + $urandom_range(1, 40);
        end else if (r < 75) begin
            first = $urandom_range(0, 3800);
            count = first + $urandom_range(60, 290);
        end else if (r < 90) begin
            // whole store, page count clipped
            first = $urandom_range(0, 40);
            count = $urandom_range(PAGES, 8191);
        end else begin
            // empty or inverted window
            first = $urandom_range(0, 8191);
            count = $urandom_range(0, first);
        end
        set_window(first, count);
        gaps_on = ($urandom_range(0, 3) != 0);
        allocs  = 0;
        repeat (PHASE_WORDS) begin
            if ($urandom_range(0, 99) < 55) begin
                send_word(MODE_ALLOC, $urandom());
                allocs++;
            end else begin
                send_word(MODE_RELEASE, pick_release(allocs));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset window: whole store, address ignored on allocate
        send_word(MODE_ALLOC, 32'h0000_0000);
        send_word(MODE_ALLOC, 32'hffff_ffff);
        send_word(MODE_ALLOC, 32'h0000_0000);
        send_word(MODE_RELEASE, 32'h0000_1000);
        // double release, misaligned, beyond the store, never allocated
        send_word(MODE_RELEASE, 32'h0000_1000);
        send_word(MODE_RELEASE, 32'h0000_1001);
        send_word(MODE_RELEASE, 32'hffff_ffff);
        send_word(MODE_RELEASE, 32'hffff_f000);
        send_word(MODE_RELEASE, 32'h0100_0000);
        send_word(MODE_RELEASE, 32'h00ff_f000);
        // first fit reuses the freed hole
        send_word(MODE_ALLOC, 32'h0000_0000);

        // page count above the store depth, high first page
        set_window(4000, 8191);
        send_word(MODE_ALLOC, 32'h0000_0000);
        send_word(MODE_RELEASE, 32'h0000_2000);
        send_word(MODE_RELEASE, 32'h00fa_0000);
        send_word(MODE_RELEASE, 32'h00ff_f000);

        // first page at the limit: nothing to hand out
        set_window(PAGES, PAGES);
        send_word(MODE_ALLOC, 32'h0000_0000);
        send_word(MODE_RELEASE, 32'h00ff_f000);

        // zero page count
        set_window(0, 0);
        send_word(MODE_ALLOC, 32'h0000_0000);
        send_word(MODE_RELEASE, 32'h0000_0000);

        // single page window whose page is already taken
        set_window(0, 1);
        send_word(MODE_ALLOC, 32'h0000_0000);
        send_word(MODE_RELEASE, 32'h0000_0000);
        send_word(MODE_ALLOC, 32'h0000_0000);

        // largest first page with the smallest count
        set_window(8191, 0);
        send_word(MODE_ALLOC, 32'h0000_0000);

        repeat (RANDOM_PHASES) run_random_phase();

        // drain, then allow the longest scan to show any stray word
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (80) @(posedge aclk);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/pfa_pkg.sv
rtl/pfa_ram.sv
rtl/pfa_front.sv
rtl/pfa_cmd_queue.sv
rtl/pfa_back.sv
rtl/page_frame_refcount_allocator.sv
verif/pfa_refcount_checker.sv
verif/tb_page_frame_refcount_allocator.sv
